>>> sv/scmc_pkg.sv
// Shared constants for the sweep-cut conductance block: field widths,
// action and register codes, and parameter defaults. No dependencies.
package scmc_pkg;

   localparam int MAX_VERTICES_DEF = 65536;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int ACT_W      = 2;
   localparam int ID_W       = 17;
   localparam int WGT_W      = 32;
   localparam int CUT_W      = 50;
   localparam int VOL_W      = 48;
   localparam int QW         = 17;
   localparam int POS_W      = 17;
   localparam int LIM_W      = 25;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_W      = 35;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 1;

   localparam logic [QW-1:0]    COND_MAX = {QW{1'b1}};
   localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};

   // Bitmap rows: one RAM word holds this many visited flags
   localparam int ROW_BITS  = 32;
   localparam int ROW_SEL_W = 5;

   localparam logic [ACT_W-1:0] ACT_BEGIN  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_EDGE   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;
   localparam logic [ACT_W-1:0] ACT_END    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_VOLUME = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BASE   = 1'd1;

endpackage

>>> sv/scmc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
module scmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/scmc_div.sv
// Restoring divider, one quotient bit per cycle, saturating at COND_MAX.
// Computes min(floor(num * 2^FRAC_BITS / den), COND_MAX). Uses scmc_pkg.
module scmc_div import scmc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CUT_W-1:0] num,
   input  logic [VOL_W-1:0] den,
   output logic             done,
   output logic [QW-1:0]    quot
);

   localparam int XW    = CUT_W + FRAC_BITS;
   localparam int HW    = XW - QW;
   localparam int RW    = VOL_W + 1;
   localparam int CMP_W = HW > VOL_W ? HW : VOL_W;
   localparam int CNT_W = $clog2(QW);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_PRE  = 2'd1;
   localparam logic [1:0] D_RUN  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [XW-1:0]    x_ff, x_in;
   logic [RW-1:0]    r_ff, r_in;
   logic [VOL_W-1:0] den_ff, den_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [HW-1:0] hi;
   logic [RW-1:0] trial;
   logic          ge;

   assign hi    = x_ff[XW-1:QW];
   assign trial = {r_ff[RW-2:0], x_ff[QW-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      r_in     = r_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               x_in     = {num, {FRAC_BITS{1'b0}}};
               den_in   = den;
               q_in     = '0;
               cnt_in   = CNT_W'(QW - 1);
               state_in = D_PRE;
            end
         end
         D_PRE: begin
            // integer part already too large: saturate
            if (CMP_W'(hi) >= CMP_W'(den_ff)) begin
               q_in     = COND_MAX;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               r_in     = RW'(hi);
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            r_in = ge ? trial - {1'b0, den_ff} : trial;
            q_in = {q_ff[QW-2:0], ge};
            x_in = x_ff << 1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

>>> sv/sweep_cut_min_conductance.sv
// Sweep-cut minimum conductance: top level with sequencer, sweep state,
// visited bitmap (scmc_ram) and serial divider (scmc_div). Uses scmc_pkg.
//
// Sequencing: a begin beat is taken in S_IDLE, an edge beat also passes
// S_EDGE (one bitmap read), and a finish beat passes S_FIN and S_PREP, then,
// unless the conductance is a special case, waits in S_DIV for the
// one-bit-per-cycle divider, which stops early when the integer part of the
// quotient already saturates. An end beat loads the result register and then
// starts a clearing pass over the bitmap, one 32-bit row per cycle, over
// ceil(min(MAX_VERTICES, 2^17) / 32) rows (2048 at the default size); the
// same pass runs after reset. During the pass req_tready is low; csr writes
// are taken at any time. If a result is still waiting when the next end beat
// arrives, the block holds until rsp_tready frees the result register.
module sweep_cut_min_conductance import scmc_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // node_id[16:0], weight[48:17], zero fill
   input  logic [ACT_W-1:0]      req_tuser,  // action[1:0]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // best_length[16:0],
                                             // min_conductance[33:17],
                                             // no_vertices[34], zero fill
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VOL_W-1:0]      csr_wdata
);

   localparam int EFF_V = MAX_VERTICES < 2**ID_W ? MAX_VERTICES : 2**ID_W;
   localparam int ROWS  = (EFF_V + ROW_BITS - 1) / ROW_BITS;
   localparam int AW    = ROWS > 1 ? $clog2(ROWS) : 1;
   localparam int CW    = FRAC_BITS + 1 > QW ? FRAC_BITS + 1 : QW;

   localparam logic [CW-1:0] COND_ONE = CW'(1) << FRAC_BITS;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EDGE  = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_PREP  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_HOLD  = 3'd6;

   function automatic logic in_range(input logic [ID_W-1:0] v);
      in_range = LIM_W'(v) < LIM_W'(MAX_VERTICES);
   endfunction

   function automatic logic [AW-1:0] row_of(input logic [ID_W-1:0] v);
      logic [ID_W-ROW_SEL_W-1:0] full;
      full   = v[ID_W-1:ROW_SEL_W];
      row_of = full[AW-1:0];
   endfunction

   // configuration
   logic [VOL_W-1:0] total_ff;
   logic             base_ff;

   // sequencer and sweep state
   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [ID_W-1:0]  cur_vertex_ff, cur_vertex_in;
   logic [WGT_W-1:0] degree_ff, degree_in;
   logic [CUT_W-1:0] change_ff, change_in;
   logic [CUT_W-1:0] cut_ff, cut_in;
   logic [VOL_W-1:0] vol_ff, vol_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CW-1:0]    best_cond_ff, best_cond_in;
   logic [POS_W-1:0] best_idx_ff, best_idx_in;
   logic             have_best_ff, have_best_in;

   // per-beat scratch
   logic                 hit_ff, hit_in;
   logic [ROW_SEL_W-1:0] bit_ff, bit_in;
   logic [WGT_W-1:0]     w_ff, w_in;
   logic [VOL_W:0]       rest_ff, rest_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // request fields
   logic [ACT_W-1:0] req_action;
   logic [ID_W-1:0]  req_node;
   logic [ID_W-1:0]  req_id;
   logic [WGT_W-1:0] req_weight;
   logic             req_fire;

   // bitmap port
   logic                ram_we;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [ROW_BITS-1:0] ram_wdata, ram_rdata;

   // divider port
   logic             div_start, div_done;
   logic [QW-1:0]    div_quot;
   logic [CUT_W-1:0] cut_mag;
   logic [VOL_W:0]   den, den_mag;

   // conductance handoff to the best tracker
   logic          upd_en;
   logic [CW-1:0] upd_val;
   logic          load_rsp, clear_sweep, can_load;
   logic          cut_neg, den_neg, vol_lt_rest;

   assign req_action = req_tuser;
   assign req_node   = req_tdata[ID_W-1:0];
   assign req_weight = req_tdata[ID_W+WGT_W-1:ID_W];
   assign req_id     = req_node - ID_W'(base_ff);
   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign can_load   = !rsp_valid_ff || rsp_tready;

   // sign and magnitude of cut and denominator for the divider
   assign vol_lt_rest = $signed({1'b0, vol_ff}) < $signed(rest_ff);
   assign den         = vol_lt_rest ? {1'b0, vol_ff} : rest_ff;
   assign den_neg     = den[VOL_W];
   assign cut_neg     = cut_ff[CUT_W-1];
   assign den_mag     = den_neg ? (VOL_W+1)'(-den) : den;
   assign cut_mag     = cut_neg ? CUT_W'(-cut_ff) : cut_ff;

   assign ram_raddr = (req_action == ACT_EDGE) ? row_of(req_id) : row_of(cur_vertex_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_vertex_in = cur_vertex_ff;
      degree_in     = degree_ff;
      change_in     = change_ff;
      cut_in        = cut_ff;
      vol_in        = vol_ff;
      pos_in        = pos_ff;
      best_cond_in  = best_cond_ff;
      best_idx_in   = best_idx_ff;
      have_best_in  = have_best_ff;
      hit_in        = hit_ff;
      bit_in        = bit_ff;
      w_in          = w_ff;
      rest_in       = rest_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_ff;
      ram_wdata     = '0;
      div_start     = 1'b0;
      upd_en        = 1'b0;
      upd_val       = '0;
      load_rsp      = 1'b0;
      clear_sweep   = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // zero one bitmap row per cycle
            ram_we = 1'b1;
            if (clr_ff == AW'(ROWS - 1)) begin
               clr_in   = '0;
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  ACT_BEGIN: begin
                     cur_vertex_in = req_id;
                     degree_in     = req_weight;
                     change_in     = CUT_W'(req_weight);
                  end
                  ACT_EDGE: begin
                     // bitmap row read is in flight; check the bit next cycle
                     hit_in   = in_range(req_id);
                     bit_in   = req_id[ROW_SEL_W-1:0];
                     w_in     = req_weight;
                     state_in = S_EDGE;
                  end
                  ACT_FINISH: begin
                     hit_in   = in_range(cur_vertex_ff);
                     cut_in   = cut_ff + change_ff;
                     vol_in   = vol_ff + VOL_W'(degree_ff);
                     pos_in   = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
                     state_in = S_FIN;
                  end
                  default: begin
                     if (can_load) begin
                        load_rsp    = 1'b1;
                        clear_sweep = 1'b1;
                        state_in    = S_CLEAR;
                     end else begin
                        state_in = S_HOLD;
                     end
                  end
               endcase
            end
         end
         S_EDGE: begin
            // edge to an already swept neighbor: drop twice its weight
            if (hit_ff && ram_rdata[bit_ff]) begin
               change_in = change_ff - CUT_W'({w_ff, 1'b0});
            end
            state_in = S_IDLE;
         end
         S_FIN: begin
            // mark the vertex swept, form total - vol
            ram_we    = hit_ff;
            ram_waddr = row_of(cur_vertex_ff);
            ram_wdata = ram_rdata | (ROW_BITS'(1) << cur_vertex_ff[ROW_SEL_W-1:0]);
            rest_in   = {1'b0, total_ff} - {1'b0, vol_ff};
            state_in  = S_PREP;
         end
         S_PREP: begin
            state_in = S_IDLE;
            if (vol_ff == '0 || rest_ff == '0) begin
               upd_en  = 1'b1;
               upd_val = COND_ONE;
            end else if (cut_ff == '0 || cut_neg != den_neg) begin
               upd_en  = 1'b1;
               upd_val = '0;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               upd_en   = 1'b1;
               upd_val  = CW'(div_quot);
               state_in = S_IDLE;
            end
         end
         S_HOLD: begin
            // result register busy: hold the end beat
            if (can_load) begin
               load_rsp    = 1'b1;
               clear_sweep = 1'b1;
               state_in    = S_CLEAR;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // keep the first minimum
      if (upd_en && (!have_best_ff || upd_val < best_cond_ff)) begin
         best_cond_in = upd_val;
         best_idx_in  = pos_ff;
         have_best_in = 1'b1;
      end

      if (clear_sweep) begin
         cur_vertex_in = '0;
         degree_in     = '0;
         change_in     = '0;
         cut_in        = '0;
         vol_in        = '0;
         pos_in        = '0;
         best_cond_in  = '0;
         best_idx_in   = '0;
         have_best_in  = 1'b0;
      end
   end

   // result register: load on end, drop when taken
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {!have_best_ff, best_cond_ff[QW-1:0], best_idx_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         base_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TOTAL_VOLUME: total_ff <= csr_wdata;
            CSR_INDEX_BASE:   base_ff  <= csr_wdata[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         cur_vertex_ff <= '0;
         degree_ff     <= '0;
         change_ff     <= '0;
         cut_ff        <= '0;
         vol_ff        <= '0;
         pos_ff        <= '0;
         best_cond_ff  <= '0;
         best_idx_ff   <= '0;
         have_best_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         cur_vertex_ff <= cur_vertex_in;
         degree_ff     <= degree_in;
         change_ff     <= change_in;
         cut_ff        <= cut_in;
         vol_ff        <= vol_in;
         pos_ff        <= pos_in;
         best_cond_ff  <= best_cond_in;
         best_idx_ff   <= best_idx_in;
         have_best_ff  <= have_best_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hit_ff      <= hit_in;
      bit_ff      <= bit_in;
      w_ff        <= w_in;
      rest_ff     <= rest_in;
      rsp_data_ff <= rsp_data_in;
   end

   scmc_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   scmc_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (cut_mag),
      .den   (den_mag[VOL_W-1:0]),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

endmodule

>>> tb/sv/sweep_cut_min_conductance_tb.sv
// Self-checking bench for sweep_cut_min_conductance: streams vertex sweeps,
// predicts each end-of-sweep result in-bench and compares every rsp beat.
// Depends on scmc_pkg and the sweep_cut_min_conductance RTL only.
module sweep_cut_min_conductance_tb;
   import scmc_pkg::*;

   localparam int MAP_SIZE     = MAX_VERTICES_DEF;
   // Covers the clearing pass after an end beat, with margin for a finish.
   localparam int SETTLE_CYCLES = 2200;
   localparam int HOLD_CYCLES   = 6000;
   localparam logic [QW-1:0] COND_ONE = QW'(1) << FRAC_BITS_DEF;

   typedef struct {
      logic [ACT_W-1:0] action;
      logic [ID_W-1:0]  node;
      logic [WGT_W-1:0] wgt;
   } sweep_beat_type;

   typedef struct {
      logic [POS_W-1:0] best_len;
      logic [QW-1:0]    best_cond;
      logic             no_vtx;
   } sweep_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACT_W-1:0]      req_tuser = ACT_BEGIN;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TOTAL_VOLUME;
   logic [VOL_W-1:0]      csr_wdata = '0;

   sweep_cut_min_conductance u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),  // node_id[16:0], weight[48:17], zero fill
      .req_tuser  (req_tuser),  // action[1:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),  // best_length[16:0], min_conductance[33:17],
                                // no_vertices[34], zero fill
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Sweep tracker: own copy of the register file and sweep state
   // ---------------------------------------------------------------------
   logic [VOL_W-1:0]    trk_total = '0;
   logic                trk_base  = 1'b0;
   bit   [MAP_SIZE-1:0] trk_swept = '0;
   logic [ID_W-1:0]     trk_vtx   = '0;
   logic [WGT_W-1:0]    trk_deg   = '0;
   logic [CUT_W-1:0]    trk_chg   = '0;
   logic [CUT_W-1:0]    trk_cut   = '0;
   logic [VOL_W-1:0]    trk_vol   = '0;
   logic [POS_W-1:0]    trk_pos   = '0;
   logic [QW-1:0]       trk_best  = '0;
   logic [POS_W-1:0]    trk_best_at = '0;
   logic                trk_have  = 1'b0;

   sweep_beat_type   pend_q[$];
   sweep_result_type sweep_results_q[$];
   sweep_beat_type   cur_beat;

   int send_idle_pct = 36;
   int recv_idle_pct = 72;
   int err_count     = 0;
   int beats_taken   = 0;
   int results_seen  = 0;
   int sat_results   = 0;
   int zero_results  = 0;
   int empty_results = 0;
   int queued_beats  = 0;

   bit hold_arm = 1'b0;
   bit hold_done;
   int hold_cnt;

   // Conductance of the current prefix: cut / min(vol, total - vol), Q1.16,
   // truncated and saturated; 1.0 when either side of the split is empty.
   function automatic logic [QW-1:0] prefix_conductance(logic [CUT_W-1:0] cut_v,
                                                        logic [VOL_W-1:0] vol_v,
                                                        logic [VOL_W-1:0] tot_v);
      longint        cut_s, vol_s, rest_s, den_s;
      longint unsigned an, ad;
      logic [65:0]   quo;
      cut_s  = {{(64-CUT_W){cut_v[CUT_W-1]}}, cut_v};
      vol_s  = {{(64-VOL_W){1'b0}}, vol_v};
      rest_s = {{(64-VOL_W){1'b0}}, tot_v} - vol_s;
      den_s  = (vol_s < rest_s) ? vol_s : rest_s;
      if (vol_s == 0 || rest_s == 0)
         return COND_ONE;
      if (cut_s == 0)
         return '0;
      // opposite signs (over-full volume or a negative cut) clamp to zero
      if ((cut_s < 0) != (den_s < 0))
         return '0;
      an  = (cut_s < 0) ? -cut_s : cut_s;
      ad  = (den_s < 0) ? -den_s : den_s;
      quo = ({2'b00, an} << FRAC_BITS_DEF) / {2'b00, ad};
      if (quo > COND_MAX)
         return COND_MAX;
      return quo[QW-1:0];
   endfunction

   task automatic advance_sweep(sweep_beat_type b);
      logic [ID_W-1:0]  id;
      logic [QW-1:0]    c;
      sweep_result_type r;
      id = b.node - {{(ID_W-1){1'b0}}, trk_base};
      case (b.action)
         ACT_BEGIN: begin
            trk_vtx = id;
            trk_deg = b.wgt;
            trk_chg = {{(CUT_W-WGT_W){1'b0}}, b.wgt};
         end
         ACT_EDGE: begin
            // only neighbors finished earlier in this sweep cut the change
            if (id < MAP_SIZE && trk_swept[id[15:0]])
               trk_chg = trk_chg - {{(CUT_W-WGT_W-1){1'b0}}, b.wgt, 1'b0};
         end
         ACT_FINISH: begin
            if (trk_vtx < MAP_SIZE)
               trk_swept[trk_vtx[15:0]] = 1'b1;
            trk_cut = trk_cut + trk_chg;
            trk_vol = trk_vol + {{(VOL_W-WGT_W){1'b0}}, trk_deg};
            if (trk_pos != POS_MAX)
               trk_pos = trk_pos + 1'b1;
            c = prefix_conductance(trk_cut, trk_vol, trk_total);
            // keep the earliest minimum
            if (!trk_have || c < trk_best) begin
               trk_best    = c;
               trk_best_at = trk_pos;
               trk_have    = 1'b1;
            end
         end
         default: begin
            r.best_len  = trk_have ? trk_best_at : '0;
            r.best_cond = trk_have ? trk_best : '0;
            r.no_vtx    = !trk_have;
            sweep_results_q.push_back(r);
            if (r.no_vtx)
               empty_results++;
            else if (r.best_cond == COND_MAX)
               sat_results++;
            else if (r.best_cond == '0)
               zero_results++;
            trk_swept   = '0;
            trk_vtx     = '0;
            trk_deg     = '0;
            trk_chg     = '0;
            trk_cut     = '0;
            trk_vol     = '0;
            trk_pos     = '0;
            trk_best    = '0;
            trk_best_at = '0;
            trk_have    = 1'b0;
         end
      endcase
   endtask

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
      err_count++;
   endtask

   task automatic check_result(logic [RSP_DATA_W-1:0] d);
      sweep_result_type want;
      if (sweep_results_q.size() == 0) begin
         report_mismatch("result beat with nothing pending, best_length", d[16:0], 0);
         return;
      end
      want = sweep_results_q.pop_front();
      results_seen++;
      if (d[16:0] != want.best_len)
         report_mismatch("best_length", d[16:0], want.best_len);
      if (d[33:17] != want.best_cond)
         report_mismatch("min_conductance", d[33:17], want.best_cond);
      if (d[34] != want.no_vtx)
         report_mismatch("no_vertices", d[34], want.no_vtx);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: pops pending beats, advances the tracker on accept
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // a beat moved on this edge: fold it into the prediction first
         if (req_tvalid && req_tready) begin
            advance_sweep(cur_beat);
            beats_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_beat   = pend_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_DATA_W-ID_W-WGT_W){1'b0}}, cur_beat.wgt, cur_beat.node};
               req_tuser  <= cur_beat.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off: once armed, keep rsp_tready low for a fixed
   // stretch so results back up and the block stalls its request side.
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt  <= 0;
         hold_done <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (hold_arm && !hold_done) begin
         hold_cnt  <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: random backpressure, compare each accepted beat
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result(rsp_tdata);
         rsp_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_beat(logic [ACT_W-1:0] act, logic [ID_W-1:0] node,
                            logic [WGT_W-1:0] wgt);
      sweep_beat_type b;
      b.action = act;
      b.node   = node;
      b.wgt    = wgt;
      pend_q.push_back(b);
      queued_beats++;
   endtask

   // Mostly small vertex ids so edges often land on swept neighbors; now and
   // then the top in-range id or an id past the bitmap.
   function automatic logic [ID_W-1:0] pick_vertex();
      case ($urandom_range(0, 19))
         0:       return ID_W'(MAP_SIZE - 1);
         1:       return ID_W'($urandom_range(MAP_SIZE, 131071));
         2:       return '0;
         default: return ID_W'($urandom_range(0, 31));
      endcase
   endfunction

   // Whole-unit weights make exact splits (rest of volume zero) reachable.
   function automatic logic [WGT_W-1:0] pick_weight(int top);
      logic [WGT_W-1:0] w;
      case ($urandom_range(0, 9))
         0:       w = '0;
         1:       w = '1;
         2:       w = $urandom;
         default: begin
            w = WGT_W'($urandom_range(1, top)) << 16;
            if ($urandom_range(0, 2) == 0)
               w[15:0] = 16'($urandom_range(0, 65535));
         end
      endcase
      return w;
   endfunction

   task automatic queue_sweep();
      logic [ID_W-1:0] swept_ids[$];
      logic [ID_W-1:0] v, nb;
      logic [ID_W-1:0] base_ext;
      int nv;
      base_ext = {{(ID_W-1){1'b0}}, trk_base};
      if ($urandom_range(0, 9) == 0) begin
         // noise: arbitrary non-end beats
         repeat ($urandom_range(1, 8))
            push_beat(ACT_W'($urandom_range(0, 2)), ID_W'($urandom), $urandom);
      end else begin
         nv = $urandom_range(0, 10);
         repeat (nv) begin
            v = pick_vertex();
            // occasionally drop the begin beat
            if ($urandom_range(0, 19) != 0)
               push_beat(ACT_BEGIN, v + base_ext, pick_weight(40));
            repeat ($urandom_range(0, 4)) begin
               if (swept_ids.size() != 0 && $urandom_range(0, 3) != 0)
                  nb = swept_ids[$urandom_range(0, swept_ids.size() - 1)];
               else
                  nb = pick_vertex();
               push_beat(ACT_EDGE, nb + base_ext, pick_weight(20));
            end
            push_beat(ACT_FINISH, ID_W'($urandom), $urandom);
            // occasionally finish the same vertex twice
            if ($urandom_range(0, 19) == 0)
               push_beat(ACT_FINISH, ID_W'($urandom), $urandom);
            swept_ids.push_back(v);
         end
      end
      push_beat(ACT_END, ID_W'($urandom), $urandom);
   endtask

   // Drain: all beats sent, all results back, then let the clearing pass run.
   task automatic wait_drained();
      @(posedge clock);
      while (pend_q.size() != 0 || req_tvalid || sweep_results_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back; only called with the block drained.
   task automatic write_csrs(logic [VOL_W-1:0] tot, logic base);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_TOTAL_VOLUME;
      csr_wdata <= tot;
      @(posedge clock);
      csr_index <= CSR_INDEX_BASE;
      csr_wdata <= {{(VOL_W-1){1'b0}}, base};
      @(posedge clock);
      csr_we    <= 1'b0;
      trk_total = tot;
      trk_base  = base;
   endtask

   task automatic run_random(logic [VOL_W-1:0] tot, logic base, int n_beats);
      int start;
      write_csrs(tot, base);
      @(negedge clock);
      start = queued_beats;
      while (queued_beats - start < n_beats)
         queue_sweep();
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [VOL_W-1:0] rnd_total;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset register values: empty sweep, then edge and finish with no
      // begin, so vertex 0 with zero degree gets swept (volume stays zero).
      push_beat(ACT_END, '0, '0);
      push_beat(ACT_EDGE, 17'd5, 32'd7);
      push_beat(ACT_FINISH, '0, '0);
      push_beat(ACT_END, '1, '1);
      wait_drained();

      // Total volume 100.0, zero-based ids.
      write_csrs(48'd100 << 16, 1'b0);
      @(negedge clock);
      push_beat(ACT_BEGIN, 17'd3, 32'd10 << 16);
      push_beat(ACT_EDGE, 17'd7, 32'd10 << 16);        // neighbor not swept yet
      push_beat(ACT_FINISH, '0, '0);
      push_beat(ACT_BEGIN, 17'd7, 32'd20 << 16);
      push_beat(ACT_EDGE, 17'd3, 32'd5 << 16);         // swept neighbor
      push_beat(ACT_EDGE, 17'd7, 32'd1);               // self edge
      push_beat(ACT_EDGE, '1, '1);                     // id past the bitmap
      push_beat(ACT_FINISH, '0, '0);
      push_beat(ACT_BEGIN, 17'd65535, 32'd69 << 16);   // one unit left: saturates
      push_beat(ACT_FINISH, '0, '0);
      push_beat(ACT_BEGIN, '1, '1);                    // overfills the volume
      push_beat(ACT_FINISH, '0, '0);
      push_beat(ACT_FINISH, '0, '0);                   // repeated finish
      push_beat(ACT_END, '0, '0);
      wait_drained();

      // Largest total volume, one-based ids: id 0 wraps past the bitmap,
      // then a heavy edge to a swept neighbor drives the cut negative.
      write_csrs('1, 1'b1);
      @(negedge clock);
      push_beat(ACT_BEGIN, '0, 32'd1);
      push_beat(ACT_FINISH, '0, '0);
      push_beat(ACT_BEGIN, 17'd65536, 32'd2 << 16);
      push_beat(ACT_FINISH, '0, '0);
      push_beat(ACT_BEGIN, 17'd1, 32'd1 << 16);
      push_beat(ACT_EDGE, 17'd65536, '1);
      push_beat(ACT_FINISH, '0, '0);
      push_beat(ACT_END, '0, '0);
      wait_drained();

      run_random(48'd300 << 16, 1'b0, 190);
      run_random('0, 1'b1, 190);

      send_idle_pct = 72;
      recv_idle_pct = 36;
      run_random('1, 1'b0, 190);
      run_random(48'd40 << 16, 1'b1, 190);

      // Back-pressure: sender streams flat out while the receiver holds off;
      // the second end beat has to wait for the result register.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csrs(48'd80 << 16, 1'b0);
      @(negedge clock);
      hold_arm = 1'b1;
      repeat (6) queue_sweep();
      wait_drained();

      rnd_total = VOL_W'({$urandom, $urandom});
      rnd_total = rnd_total >> $urandom_range(8, 40);
      run_random(rnd_total, 1'($urandom_range(0, 1)), 190);
      run_random(48'd25 << 16, 1'b0, 190);

      $display("run: %0d request beats, %0d sweep results checked", beats_taken, results_seen);
      $display("results: %0d empty sweeps, %0d saturated, %0d zero conductance",
               empty_results, sat_results, zero_results);
      if (err_count == 0 && sweep_results_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #4800000;
      $display("simulation failed");
      $finish;
   end

endmodule
